// ----- hw/rtl/vbs_pkg.sv -----
// Shared types, constants and fixed-point helpers for the Verlet body store.
// Used by vbs_mul, vbs_store and verlet_body_store_core; depends on nothing.
package vbs_pkg;

  localparam int MAX_BODIES = 256;
  localparam int IDX_W      = $clog2(MAX_BODIES);
  localparam int CNT_W      = $clog2(MAX_BODIES + 1);

  localparam int PROD_W = 48;

  typedef enum logic [1:0] {
    FUNC_STEP = 2'd0,
    FUNC_SET  = 2'd1,
    FUNC_ADD  = 2'd2,
    FUNC_READ = 2'd3
  } func_e;

  localparam logic [1:0] CFG_BODIES  = 2'd0;
  localparam logic [1:0] CFG_TSTEP   = 2'd1;
  localparam logic [1:0] CFG_GRAVITY = 2'd2;

  localparam logic [15:0] TSTEP_RESET = 16'd1092;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DT,
    S_RD,
    S_MX,
    S_MY,
    S_WB,
    S_DONE
  } state_e;

  typedef struct packed {
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic signed [31:0] prev_x;
    logic signed [31:0] prev_y;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
  } body_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    body_t            row;
  } store_wr_t;

  // Clamp a widened sum to signed 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if ((v[34:31] == 4'b0000) || (v[34:31] == 4'b1111)) begin
      r = v[31:0];
    end else if (v[34]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  // 2*pos - prev + acc*dt^2, product rounded half up to Q16.16, saturated.
  function automatic logic signed [31:0] advance(input logic signed [31:0] pos,
                                                 input logic signed [31:0] prev,
                                                 input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    logic signed [31:0]       term;
    logic signed [34:0]       sum;
    t    = p + 48'sd32768;
    term = t[47:16];
    sum  = (35'(pos) <<< 1) - 35'(prev) + 35'(term);
    return sat32(sum);
  endfunction

endpackage

// ----- hw/rtl/vbs_mul.sv -----
// Shared signed multiplier for the body store: 32-bit signed by 16-bit unsigned,
// product registered. Depends on vbs_pkg.
module vbs_mul
  import vbs_pkg::*;
(
  input  logic                     clk_i,
  input  logic signed [31:0]       a_i,
  input  logic        [15:0]       b_i,
  output logic signed [PROD_W-1:0] p_o
);

  // the full product of a signed 32-bit and an unsigned 16-bit operand fits 48 bits
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] p_q;

  assign prod = a_i * $signed({1'b0, b_i});

  always_ff @(posedge clk_i) begin
    p_q <= prod;
  end

  assign p_o = p_q;

endmodule

// ----- hw/rtl/vbs_store.sv -----
// Body memory: one row per body, one write and one registered read per cycle.
// Rows never written since reset read as zero. Depends on vbs_pkg.
module vbs_store
  import vbs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  store_wr_t        wr_i,
  input  logic [IDX_W-1:0] raddr_i,
  output body_t            rdata_o
);

  body_t                 mem_q [MAX_BODIES];
  body_t                 rdata_q;
  logic [MAX_BODIES-1:0] valid_q;
  logic                  rvalid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.row;
    end
    rdata_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_i.we) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

// ----- hw/rtl/verlet_body_store_core.sv -----
// Verlet body store top level: configuration registers, operation sequencer
// and result register. Depends on vbs_pkg, vbs_mul and vbs_store.

// Each item is one operation on a store of 256 two-dimensional bodies. A step
// (func 0) updates n = min(bodies_in_use, 256) bodies, none when n is 0, with
// one shared multiplier doing X then Y for each body and one row read and
// write through the store per body; set, add and read each handle one body,
// and an index outside the store goes straight to the done state. A finished
// result waits while an earlier one is still held and stalled in the output
// register. The block takes no new item until the current one is finished; a
// finished result waits in the output register while the next item is
// accepted. The store reads as zero after reset with no clearing pass.
// Configuration writes are taken at any time but must only be issued while
// the block is idle.
module verlet_body_store_core
  import vbs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  // operation items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [15:0]        body_index_i,
  input  logic signed [31:0] value_x_i,
  input  logic signed [31:0] value_y_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic               status_o
);

  logic [8:0]         biu_q;
  logic [15:0]        ts_q;
  logic signed [31:0] grav_q;

  state_e             state_q, state_d;
  func_e              func_q, func_d;
  logic [IDX_W-1:0]   body_q, body_d;
  logic [CNT_W-1:0]   n_q, n_d;
  logic signed [31:0] vx_q, vx_d, vy_q, vy_d;
  logic [15:0]        dt2_q, dt2_d;
  logic signed [31:0] ay_q, ay_d, nx_q, nx_d;
  logic signed [31:0] rx_q, rx_d, ry_q, ry_d;
  logic               st_q, st_d;
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic               out_st_q, out_st_d;

  logic               in_acc;
  logic               idx_oor;
  logic [CNT_W-1:0]   n_lim;
  logic [32:0]        dt2_sum;
  logic signed [31:0] mul_a;
  logic [15:0]        mul_b;
  logic signed [PROD_W-1:0] mul_p;
  body_t              row;
  store_wr_t          wr;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign idx_oor     = (32'(body_index_i) >= 32'(MAX_BODIES));
  assign n_lim       = (32'(biu_q) > 32'(MAX_BODIES)) ? CNT_W'(MAX_BODIES) : CNT_W'(biu_q);
  assign dt2_sum     = 33'(mul_p[31:0]) + 33'd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      biu_q  <= '0;
      ts_q   <= TSTEP_RESET;
      grav_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_BODIES:  biu_q  <= cfg_data_i[8:0];
        CFG_TSTEP:   ts_q   <= cfg_data_i[15:0];
        CFG_GRAVITY: grav_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  vbs_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  vbs_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .raddr_i (body_q),
    .rdata_o (row)
  );

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    body_d      = body_q;
    n_d         = n_q;
    vx_d        = vx_q;
    vy_d        = vy_q;
    dt2_d       = dt2_q;
    ay_d        = ay_q;
    nx_d        = nx_q;
    rx_d        = rx_q;
    ry_d        = ry_q;
    st_d        = st_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_st_d    = out_st_q;
    out_valid_d = out_valid_q && out_stall_i;
    mul_a       = 32'(ts_q);
    mul_b       = ts_q;
    wr.we       = 1'b0;
    wr.addr     = body_q;
    wr.row      = row;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          func_d = func_e'(func_i);
          vx_d   = value_x_i;
          vy_d   = value_y_i;
          rx_d   = '0;
          ry_d   = '0;
          st_d   = 1'b0;
          if (func_e'(func_i) == FUNC_STEP) begin
            body_d  = '0;
            n_d     = n_lim;
            state_d = (n_lim == '0) ? S_DONE : S_DT;
          end else if (idx_oor) begin
            st_d    = 1'b1;
            state_d = S_DONE;
          end else begin
            body_d  = body_index_i[IDX_W-1:0];
            state_d = S_RD;
          end
        end
      end
      S_DT: begin
        // ts^2 is in the product register: round to Q0.16
        dt2_d   = dt2_sum[31:16];
        state_d = S_RD;
      end
      S_RD: begin
        state_d = S_MX;
      end
      S_MX: begin
        mul_b = dt2_q;
        unique case (func_q)
          FUNC_STEP: begin
            mul_a   = row.acc_x;
            ay_d    = sat32(35'(row.acc_y) + 35'(grav_q));
            state_d = S_MY;
          end
          FUNC_SET: begin
            wr.we         = 1'b1;
            wr.row.cur_x  = vx_q;
            wr.row.prev_x = vx_q;
            wr.row.cur_y  = vy_q;
            wr.row.prev_y = vy_q;
            state_d       = S_DONE;
          end
          FUNC_ADD: begin
            wr.we        = 1'b1;
            wr.row.acc_x = sat32(35'(row.acc_x) + 35'(vx_q));
            wr.row.acc_y = sat32(35'(row.acc_y) + 35'(vy_q));
            state_d      = S_DONE;
          end
          FUNC_READ: begin
            rx_d    = row.cur_x;
            ry_d    = row.cur_y;
            state_d = S_DONE;
          end
          default: ;
        endcase
      end
      S_MY: begin
        mul_a   = ay_q;
        mul_b   = dt2_q;
        nx_d    = advance(row.cur_x, row.prev_x, mul_p);
        state_d = S_WB;
      end
      S_WB: begin
        wr.we         = 1'b1;
        wr.row.cur_x  = nx_q;
        wr.row.cur_y  = advance(row.cur_y, row.prev_y, mul_p);
        wr.row.prev_x = row.cur_x;
        wr.row.prev_y = row.cur_y;
        wr.row.acc_x  = '0;
        wr.row.acc_y  = '0;
        if ((CNT_W'(body_q) + CNT_W'(1)) == n_q) begin
          state_d = S_DONE;
        end else begin
          body_d  = body_q + IDX_W'(1);
          state_d = S_RD;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_x_d     = rx_q;
          out_y_d     = ry_q;
          out_st_d    = st_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      func_q      <= FUNC_STEP;
      body_q      <= '0;
      n_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      func_q      <= func_d;
      body_q      <= body_d;
      n_q         <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vx_q     <= vx_d;
    vy_q     <= vy_d;
    dt2_q    <= dt2_d;
    ay_q     <= ay_d;
    nx_q     <= nx_d;
    rx_q     <= rx_d;
    ry_q     <= ry_d;
    st_q     <= st_d;
    out_x_q  <= out_x_d;
    out_y_q  <= out_y_d;
    out_st_q <= out_st_d;
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_x_q;
  assign pos_y_o     = out_y_q;
  assign status_o    = out_st_q;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("block not busy after taking an item");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result raised outside the done state");

  a_write_in_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.we |-> (state_q == S_MX || state_q == S_WB))
    else $error("store written outside an update state");

  a_body_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (func_q == FUNC_STEP && (state_q == S_RD || state_q == S_MX ||
     state_q == S_MY || state_q == S_WB)) |-> (CNT_W'(body_q) < n_q))
    else $error("step counter beyond body count");

  a_status_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && st_q) |-> (rx_q == '0 && ry_q == '0))
    else $error("out-of-range result carries position");
`endif

endmodule
